>>> rtl/fbw_pkg.sv
// Shared types, constants and the 5x8 font table for the glyph framebuffer writer.
// No dependencies.
package fbw_pkg;

   localparam int unsigned COORD_W    = 10;
   localparam int unsigned ADDR_W     = 17;
   localparam int unsigned COLOR_W    = 16;
   localparam int unsigned CODE_W     = 8;
   localparam int unsigned GLYPH_IDX_W = 7;

   localparam logic [7:0] FONT_FIRST = 8'd32;
   localparam logic [7:0] FONT_LAST  = 8'd127;
   localparam logic [2:0] COL_LAST   = 3'd4;   // five columns
   localparam logic [2:0] ROW_LAST   = 3'd7;   // eight rows
   localparam logic [10:0] ADVANCE   = 11'd6;
   localparam logic [10:0] CURSOR_MAX = 11'd1023;

   typedef enum logic [1:0] {
      ADDR_HOLD,
      ADDR_LOAD,
      ADDR_NEXT_ROW,
      ADDR_NEXT_COL
   } addr_op_type;

   typedef struct packed {
      addr_op_type        op;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } addr_ctl_type;

   // one entry per glyph, column 0 in the top byte; bit r of a column is row r
   localparam logic [39:0] FONT_ROM [96] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
   };

   function automatic logic [7:0] font_column(input logic [GLYPH_IDX_W-1:0] idx,
                                              input logic [2:0] col);
      logic [39:0] entry;
      logic [5:0]  sh;
      entry = FONT_ROM[idx];
      sh    = 6'd32 - {col, 3'b000};
      return entry[sh +: 8];
   endfunction

   function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
      logic [GLYPH_IDX_W-1:0] idx;
      if (code < FONT_FIRST || code > FONT_LAST) begin
         idx = '0;
      end else begin
         idx = code[GLYPH_IDX_W-1:0] - 7'd32;
      end
      return idx;
   endfunction

endpackage

>>> rtl/fbw_addr_unit.sv
// Framebuffer address generator: one multiply at load, then a single shared adder
// that steps down a column or over to the next one. Depends on fbw_pkg.
module fbw_addr_unit #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic                          clock,
   input  fbw_pkg::addr_ctl_type         ctl,
   output logic [fbw_pkg::ADDR_W-1:0]    addr
);

   localparam logic [fbw_pkg::COORD_W-1:0] SCR_W = fbw_pkg::COORD_W'(SCREEN_WIDTH);

   logic [fbw_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [fbw_pkg::ADDR_W-1:0] col_addr_ff, col_addr_in;
   logic [2*fbw_pkg::COORD_W-1:0] prod;
   logic [fbw_pkg::ADDR_W-1:0] add_a, add_b, sum;

   assign prod = (2*fbw_pkg::COORD_W)'(ctl.y) * (2*fbw_pkg::COORD_W)'(SCR_W);

   // shared adder: load adds x to y*width, next row adds the width, next column adds one to the column base
   always_comb begin
      add_a = addr_ff;
      add_b = fbw_pkg::ADDR_W'(SCR_W);
      case (ctl.op)
         fbw_pkg::ADDR_LOAD: begin
            add_a = prod[fbw_pkg::ADDR_W-1:0];
            add_b = fbw_pkg::ADDR_W'(ctl.x);
         end
         fbw_pkg::ADDR_NEXT_COL: begin
            add_a = col_addr_ff;
            add_b = fbw_pkg::ADDR_W'(1);
         end
         default: begin
            add_a = addr_ff;
            add_b = fbw_pkg::ADDR_W'(SCR_W);
         end
      endcase
      sum = add_a + add_b;
   end

   always_comb begin
      addr_in     = addr_ff;
      col_addr_in = col_addr_ff;
      case (ctl.op)
         fbw_pkg::ADDR_LOAD, fbw_pkg::ADDR_NEXT_COL: begin
            addr_in     = sum;
            col_addr_in = sum;
         end
         fbw_pkg::ADDR_NEXT_ROW: begin
            addr_in = sum;
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      col_addr_ff <= col_addr_in;
   end

   assign addr = addr_ff;

endmodule

>>> rtl/glyph_to_framebuffer_writer_unit.sv
// Top level of the 5x8 glyph framebuffer writer: sequencer, clipping, cursor, output register.
// Depends on fbw_pkg and fbw_addr_unit.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | char_code, start_x, row_y, foreground,
//          |           |                       | background, continue_line
//  rsp     | out       | rsp_valid / rsp_ready | pixel_address, pixel_color, write_enable, last
//
// Per character: a setup step on acceptance (glyph lookup, y*width+x, clip limits), then
// a walk over the glyph cells column by column, one cell per cycle while rsp does not stall,
// stopping after the last visible cell. The pace is set by the single address adder.
// A fully clipped character gives one no-write transaction after the setup step.
// Reset clears the sequencer, the output valid flag and the text cursor to zero.
// A stall on rsp freezes the cell walk; req_ready is high only between characters,
// and a finished transaction may still wait in the output register while a new one is taken.
module glyph_to_framebuffer_writer_unit #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fbw_pkg::CODE_W-1:0]       req_char_code,
   input  logic [fbw_pkg::COORD_W-1:0]      req_start_x,
   input  logic [fbw_pkg::COORD_W-1:0]      req_row_y,
   input  logic [fbw_pkg::COLOR_W-1:0]      req_foreground,
   input  logic [fbw_pkg::COLOR_W-1:0]      req_background,
   input  logic                             req_continue_line,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fbw_pkg::ADDR_W-1:0]       rsp_pixel_address,
   output logic [fbw_pkg::COLOR_W-1:0]      rsp_pixel_color,
   output logic                             rsp_write_enable,
   output logic                             rsp_last
);

   localparam logic [fbw_pkg::COORD_W:0] SCR_W = (fbw_pkg::COORD_W+1)'(SCREEN_WIDTH);
   localparam logic [fbw_pkg::COORD_W:0] SCR_H = (fbw_pkg::COORD_W+1)'(SCREEN_HEIGHT);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_EMPTY
   } state_type;

   state_type                         state_ff, state_in;
   logic [fbw_pkg::COORD_W-1:0]       cursor_ff, cursor_in;
   logic [fbw_pkg::GLYPH_IDX_W-1:0]   idx_ff, idx_in;
   logic [fbw_pkg::COLOR_W-1:0]       fg_ff, fg_in, bg_ff, bg_in;
   logic [2:0]                        col_ff, col_in, row_ff, row_in;
   logic [2:0]                        last_col_ff, last_col_in, last_row_ff, last_row_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fbw_pkg::ADDR_W-1:0]        rsp_addr_ff, rsp_addr_in;
   logic [fbw_pkg::COLOR_W-1:0]       rsp_color_ff, rsp_color_in;
   logic                              rsp_we_ff, rsp_we_in;
   logic                              rsp_last_ff, rsp_last_in;

   fbw_pkg::addr_ctl_type             addr_ctl;
   logic [fbw_pkg::ADDR_W-1:0]        cell_addr;

   logic                              accept;
   logic                              slot_free;
   logic [fbw_pkg::COORD_W-1:0]       x_sel;
   logic [fbw_pkg::COORD_W:0]         x_adv;
   logic                              any_visible;
   logic [2:0]                        lim_col, lim_row;
   logic                              cell_visible, cell_last;
   logic [7:0]                        glyph_col;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign x_sel     = req_continue_line ? cursor_ff : req_start_x;
   assign x_adv     = {1'b0, x_sel} + fbw_pkg::ADVANCE;

   // columns and rows inside the screen form a prefix, so only the last one is kept
   always_comb begin
      lim_col = '0;
      lim_row = '0;
      for (int c = 0; c <= 4; c++) begin
         if (({1'b0, x_sel} + (fbw_pkg::COORD_W+1)'(c)) < SCR_W) begin
            lim_col = 3'(c);
         end
      end
      for (int r = 0; r <= 7; r++) begin
         if (({1'b0, req_row_y} + (fbw_pkg::COORD_W+1)'(r)) < SCR_H) begin
            lim_row = 3'(r);
         end
      end
   end

   assign any_visible  = ({1'b0, x_sel} < SCR_W) && ({1'b0, req_row_y} < SCR_H);
   assign cell_visible = (col_ff <= last_col_ff) && (row_ff <= last_row_ff);
   assign cell_last    = (col_ff == last_col_ff) && (row_ff == last_row_ff);
   assign glyph_col    = fbw_pkg::font_column(idx_ff, col_ff);

   fbw_addr_unit #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_addr (
      .clock (clock),
      .ctl   (addr_ctl),
      .addr  (cell_addr)
   );

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      idx_in       = idx_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_color_in = rsp_color_ff;
      rsp_we_in    = rsp_we_ff;
      rsp_last_in  = rsp_last_ff;
      addr_ctl.op  = fbw_pkg::ADDR_HOLD;
      addr_ctl.y   = req_row_y;
      addr_ctl.x   = x_sel;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               addr_ctl.op = fbw_pkg::ADDR_LOAD;
               idx_in      = fbw_pkg::glyph_index(req_char_code);
               fg_in       = req_foreground;
               bg_in       = req_background;
               col_in      = '0;
               row_in      = '0;
               last_col_in = lim_col;
               last_row_in = lim_row;
               cursor_in   = (x_adv > fbw_pkg::CURSOR_MAX) ?
                             fbw_pkg::CURSOR_MAX[fbw_pkg::COORD_W-1:0] :
                             x_adv[fbw_pkg::COORD_W-1:0];
               state_in    = any_visible ? S_RUN : S_EMPTY;
            end
         end
         S_RUN: begin
            if (slot_free) begin
               if (cell_visible) begin
                  rsp_valid_in = 1'b1;
                  rsp_addr_in  = cell_addr;
                  rsp_color_in = glyph_col[row_ff] ? fg_ff : bg_ff;
                  rsp_we_in    = 1'b1;
                  rsp_last_in  = cell_last;
               end
               if (cell_last) begin
                  state_in = S_IDLE;
               end
               if (row_ff == fbw_pkg::ROW_LAST) begin
                  row_in      = '0;
                  col_in      = col_ff + 3'd1;
                  addr_ctl.op = fbw_pkg::ADDR_NEXT_COL;
               end else begin
                  row_in      = row_ff + 3'd1;
                  addr_ctl.op = fbw_pkg::ADDR_NEXT_ROW;
               end
            end
         end
         S_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               rsp_color_in = '0;
               rsp_we_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      fg_ff       <= fg_in;
      bg_ff       <= bg_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      last_col_ff <= last_col_in;
      last_row_ff <= last_row_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_color_ff <= rsp_color_in;
      rsp_we_ff    <= rsp_we_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_last          = rsp_last_ff;

   // a transaction without a pixel write only ever closes a character
   a_nowrite_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_enable) |-> rsp_last)
      else $error("no-write transaction without last");

   // the writer leaves idle right after a character is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready stayed high after a character was taken");

   // ready only drops because a character was taken
   a_ready_falls_on_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("ready fell without an accepted character");

endmodule

>>> dv/glyph_pixel_checker.sv
// Checker for the glyph framebuffer writer: watches both channels, predicts the pixel writes.
// Depends on fbw_pkg for port widths only; holds its own copy of the 5x8 font.
module glyph_pixel_checker #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [fbw_pkg::CODE_W-1:0]   req_char_code,
   input  logic [fbw_pkg::COORD_W-1:0]  req_start_x,
   input  logic [fbw_pkg::COORD_W-1:0]  req_row_y,
   input  logic [fbw_pkg::COLOR_W-1:0]  req_foreground,
   input  logic [fbw_pkg::COLOR_W-1:0]  req_background,
   input  logic                         req_continue_line,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [fbw_pkg::ADDR_W-1:0]   rsp_pixel_address,
   input  logic [fbw_pkg::COLOR_W-1:0]  rsp_pixel_color,
   input  logic                         rsp_write_enable,
   input  logic                         rsp_last,
   output int unsigned                  pixels_pending,
   output int unsigned                  pixel_errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FIRST_PRINTABLE = 32;
   localparam int unsigned LAST_PRINTABLE  = 127;
   localparam int unsigned CELL_COLS       = 5;
   localparam int unsigned CELL_ROWS       = 8;
   localparam int unsigned CHAR_PITCH      = 6;
   localparam int unsigned CURSOR_LIMIT    = 1023;
   localparam int unsigned REPORT_LIMIT    = 10;

   // column 0 in the top byte, bit r of a column is row r
   localparam logic [0:95][39:0] GLYPHS = {
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
      40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
   };

   typedef struct packed {
      logic [fbw_pkg::ADDR_W-1:0]  address;
      logic [fbw_pkg::COLOR_W-1:0] color;
      logic                        wr_en;
      logic                        last;
   } pixel_write_type;

   pixel_write_type expected_pixels[$];
   logic [9:0]      text_cursor;
   int unsigned     errors;

   initial begin
      text_cursor    = '0;
      errors         = 0;
      pixels_pending = 0;
      pixel_errors   = 0;
   end

   // queues every pixel write one character causes, and moves the cursor on
   function automatic void predict_glyph_pixels(input logic [7:0]  code,
                                                input logic [9:0]  sx,
                                                input logic [9:0]  y,
                                                input logic [15:0] fg,
                                                input logic [15:0] bg,
                                                input logic        cont);
      int unsigned     x, px, py, glyph, col, row, next_x;
      logic [39:0]     entry;
      logic [7:0]      column;
      pixel_write_type pw, held;
      bit              have_held;
      x         = cont ? int'(text_cursor) : int'(sx);
      glyph     = (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) ?
                  0 : int'(code) - FIRST_PRINTABLE;
      entry     = GLYPHS[glyph];
      have_held = 1'b0;
      held      = '0;
      for (col = 0; col < CELL_COLS; col++) begin
         px = x + col;
         if (px < SCREEN_WIDTH) begin
            column = entry[39 - 8*col -: 8];
            for (row = 0; row < CELL_ROWS; row++) begin
               py = int'(y) + row;
               if (py < SCREEN_HEIGHT) begin
                  pw.address = fbw_pkg::ADDR_W'(py * SCREEN_WIDTH + px);
                  pw.color   = column[row] ? fg : bg;
                  pw.wr_en   = 1'b1;
                  pw.last    = 1'b0;
                  // hold one back so the final write can carry last
                  if (have_held) expected_pixels.push_back(held);
                  held      = pw;
                  have_held = 1'b1;
               end
            end
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_pixels.push_back(held);
      end else begin
         // nothing visible: a single no-write marker
         pw      = '0;
         pw.last = 1'b1;
         expected_pixels.push_back(pw);
      end
      next_x      = x + CHAR_PITCH;
      text_cursor = (next_x > CURSOR_LIMIT) ? 10'(CURSOR_LIMIT) : 10'(next_x);
   endfunction

   always @(posedge clock) begin : monitor
      pixel_write_type got, want;
      if (reset) begin
         text_cursor = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pixel_address, rsp_pixel_color, rsp_write_enable, rsp_last};
            if (expected_pixels.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t unexpected transaction: addr %0d colour %h we %b last %b",
                           $realtime, got.address, got.color, got.wr_en, got.last);
            end else begin
               want = expected_pixels.pop_front();
               if (got.address != want.address || got.color != want.color ||
                   got.wr_en != want.wr_en || got.last != want.last) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t mismatch: addr %0d/%0d colour %h/%h we %b/%b last %b/%b %s",
                              $realtime, want.address, got.address, want.color, got.color,
                              want.wr_en, got.wr_en, want.last, got.last, "(exp/act)");
               end
            end
         end
         if (req_valid && req_ready)
            predict_glyph_pixels(req_char_code, req_start_x, req_row_y,
                                 req_foreground, req_background, req_continue_line);
      end
      pixels_pending <= expected_pixels.size();
      pixel_errors   <= errors;
   end

endmodule

>>> dv/testbench.sv
// Top of the glyph framebuffer writer bench: clock, reset, character stimulus, output stalls.
// Depends on fbw_pkg, glyph_to_framebuffer_writer_unit and glyph_pixel_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int RANDOM_CHARS  = 300;
   localparam int DRAIN_EVERY   = 100;
   // covers one character's setup and cell walk, with margin
   localparam int SETTLE_CYCLES = 60;

   logic                         clock             = 1'b0;
   logic                         reset             = 1'b1;
   logic                         req_valid         = 1'b0;
   logic                         req_ready;
   logic [fbw_pkg::CODE_W-1:0]   req_char_code     = '0;
   logic [fbw_pkg::COORD_W-1:0]  req_start_x       = '0;
   logic [fbw_pkg::COORD_W-1:0]  req_row_y         = '0;
   logic [fbw_pkg::COLOR_W-1:0]  req_foreground    = '0;
   logic [fbw_pkg::COLOR_W-1:0]  req_background    = '0;
   logic                         req_continue_line = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready         = 1'b1;
   logic [fbw_pkg::ADDR_W-1:0]   rsp_pixel_address;
   logic [fbw_pkg::COLOR_W-1:0]  rsp_pixel_color;
   logic                         rsp_write_enable;
   logic                         rsp_last;

   int unsigned pixels_pending;
   int unsigned pixel_errors;
   int unsigned ready_left   = 0;
   bit          quiet_sender = 1'b0;

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   glyph_to_framebuffer_writer_unit #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_start_x       (req_start_x),
      .req_row_y         (req_row_y),
      .req_foreground    (req_foreground),
      .req_background    (req_background),
      .req_continue_line (req_continue_line),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last          (rsp_last)
   );

   glyph_pixel_checker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_start_x       (req_start_x),
      .req_row_y         (req_row_y),
      .req_foreground    (req_foreground),
      .req_background    (req_background),
      .req_continue_line (req_continue_line),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last          (rsp_last),
      .pixels_pending    (pixels_pending),
      .pixel_errors      (pixel_errors)
   );

   // Output back-pressure: alternating ready runs and stalls. Stalls are mostly short and
   // a few are long; some ready runs are long enough that whole characters
   // also go through with no stall at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         ready_left <= 0;
      end else if (ready_left != 0) begin
         ready_left <= ready_left - 1;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         case ($urandom_range(0, 19))
            0:       ready_left <= $urandom_range(20, 40);
            1, 2, 3: ready_left <= $urandom_range(3, 8);
            default: ready_left <= $urandom_range(0, 2);
         endcase
      end else begin
         rsp_ready <= 1'b1;
         case ($urandom_range(0, 9))
            0:          ready_left <= $urandom_range(100, 300);
            1, 2, 3:    ready_left <= $urandom_range(7, 40);
            default:    ready_left <= $urandom_range(1, 6);
         endcase
      end
   end

   // idle cycles before the next character; none while quiet_sender is set
   function automatic int unsigned sender_gap();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (quiet_sender)  return 0;
      if (pick == 0)     return $urandom_range(8, 30);
      if (pick < 7)      return $urandom_range(1, 3);
      return 0;
   endfunction

   // mostly printable, sometimes anything
   function automatic logic [7:0] pick_code();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(32, 127));
   endfunction

   // mostly on or just past the screen, sometimes the whole coordinate range
   function automatic logic [9:0] pick_coord(input int unsigned edge_limit);
      if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
      return 10'($urandom_range(0, edge_limit + 8));
   endfunction

   // Called at a rising edge: either right after the previous transaction was taken (valid
   // then stays high unless a gap is drawn) or once at the start. Returns at the edge that takes it.
   task automatic send_char(input logic [7:0]  code,
                            input logic [9:0]  sx,
                            input logic [9:0]  y,
                            input logic [15:0] fg,
                            input logic [15:0] bg,
                            input logic        cont);
      int unsigned gap;
      gap = sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_char_code     <= code;
      req_start_x       <= sx;
      req_row_y         <= y;
      req_foreground    <= fg;
      req_background    <= bg;
      req_continue_line <= cont;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender off until every predicted write has been seen
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_pending != 0);
   endtask

   initial begin : stimulus
      int unsigned sent, next_drain, run, i;
      logic [9:0]  line_x, line_y;
      logic [15:0] fg, bg;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_char("A", 10'd0, 10'd0, 16'hFFFF, 16'h0000, 1'b0);    // top-left corner
      send_char(8'd0, 10'd10, 10'd10, 16'h1234, 16'hABCD, 1'b0); // below font range: space
      send_char(8'd31, 10'd0, 10'd0, 16'h0000, 16'hFFFF, 1'b1);  // continues at cursor
      send_char(8'd32, 10'd0, 10'd0, 16'hF800, 16'h07E0, 1'b1);
      send_char(8'd127, 10'd0, 10'd0, 16'h001F, 16'hFFE0, 1'b1); // last glyph
      send_char(8'd128, 10'd100, 10'd100, 16'h5555, 16'hAAAA, 1'b0); // above font range
      send_char(8'd255, 10'd200, 10'd50, 16'hAAAA, 16'h5555, 1'b0);
      send_char("@", 10'd316, 10'd20, 16'hFFFF, 16'h0000, 1'b0); // last column clipped
      send_char("W", 10'd319, 10'd236, 16'h0F0F, 16'hF0F0, 1'b0); // bottom-right corner
      send_char("M", 10'd320, 10'd0, 16'hFFFF, 16'hFFFF, 1'b0);  // fully clipped, right
      send_char("H", 10'd0, 10'd240, 16'hFFFF, 16'hFFFF, 1'b0);  // fully clipped, below
      send_char("#", 10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF, 1'b0); // cursor saturates
      send_char("j", 10'd0, 10'd0, 16'h1111, 16'h2222, 1'b1);    // cursor stays at the top
      send_char("k", 10'd1017, 10'd0, 16'h3333, 16'h4444, 1'b0); // lands exactly on the top
      send_char("Z", 10'd314, 10'd232, 16'h0000, 16'hFFFF, 1'b0);
      send_char("b", 10'd0, 10'd0, 16'h0000, 16'hFFFF, 1'b1);    // starts just past the right edge, fully clipped
      send_char("a", 10'd0, 10'd239, 16'hFFFF, 16'h0000, 1'b0);  // one row visible
      send_char("~", 10'd5, 10'd233, 16'h7BEF, 16'h8410, 1'b0);
      send_char("g", 10'd0, 10'd233, 16'h7BEF, 16'h8410, 1'b1);
      wait_drained();

      // random part: mostly lines of text built on the cursor, some loose characters
      sent       = 0;
      next_drain = DRAIN_EVERY;
      while (sent < RANDOM_CHARS) begin
         quiet_sender = ($urandom_range(0, 3) == 0);
         fg = 16'($urandom);
         bg = 16'($urandom);
         if ($urandom_range(0, 3) != 0) begin
            line_x = pick_coord(SCREEN_WIDTH);
            line_y = pick_coord(SCREEN_HEIGHT);
            run    = $urandom_range(1, 12);
            send_char(pick_code(), line_x, line_y, fg, bg, 1'b0);
            for (i = 0; i < run; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  fg = 16'($urandom);
                  bg = 16'($urandom);
               end
               // start_x is ignored here, so it carries noise
               send_char(pick_code(), 10'($urandom), line_y, fg, bg, 1'b1);
            end
            sent += run + 1;
         end else begin
            send_char(8'($urandom), 10'($urandom), 10'($urandom), fg, bg,
                      1'($urandom));
            sent++;
         end
         if (sent >= next_drain) begin
            wait_drained();
            next_drain += DRAIN_EVERY;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pixel_errors == 0 && pixels_pending == 0) begin
         $display("PASS glyph_to_framebuffer_writer_unit");
      end else begin
         $display("FAIL glyph_to_framebuffer_writer_unit");
      end
      $finish;
   end

   // watchdog, well above the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL glyph_to_framebuffer_writer_unit");
      $finish;
   end

endmodule

>>> filelist.f
rtl/fbw_pkg.sv
rtl/fbw_addr_unit.sv
rtl/glyph_to_framebuffer_writer_unit.sv
dv/glyph_pixel_checker.sv
dv/testbench.sv
